@@ hw/rtl/ttceb_pkg.sv @@
// shared constants, types and cosine table for the time-to-collision brake
`default_nettype none

package ttceb_pkg;

  localparam int MAX_BEAMS   = 2048;
  localparam int COS_ENTRIES = 1024;

  localparam int BEAM_W  = $clog2(MAX_BEAMS);
  localparam int COS_AW  = $clog2(COS_ENTRIES + 1);
  localparam int COS_W   = 15;
  localparam int START_W = 19;
  localparam int STEP_W  = 16;
  localparam int TTC_W   = 16;
  localparam int SPEED_W = 16;
  localparam int RANGE_W = 16;

  // angle reduction datapath
  localparam int ANG_W     = BEAM_W + STEP_W + 1;
  localparam int MOD_STEPS = ANG_W - 18;
  localparam int SH_W      = (ANG_W > COS_AW + 17) ? ANG_W : COS_AW + 17;
  localparam int CNT_W     = $clog2(SH_W);

  localparam logic [SH_W-1:0] TWO_PI_Q16  = SH_W'(411775);
  localparam logic [SH_W-1:0] PI_Q16      = SH_W'(205887);
  localparam logic [SH_W-1:0] HALF_PI_Q16 = SH_W'(102944);
  localparam logic [SH_W-1:0] HALF_ROUND  = SH_W'(51472);
  localparam logic [SH_W-1:0] COS_SCALE   = SH_W'(COS_ENTRIES);
  localparam logic [COS_AW-1:0] COS_LAST  = COS_AW'(COS_ENTRIES);

  // ttc divider
  localparam int NUM_W  = RANGE_W + 10 + 15;
  localparam int DEN_W  = 31;
  localparam int QUO_W  = TTC_W;
  localparam int DSH_W  = DEN_W + QUO_W;
  localparam int DCNT_W = $clog2(QUO_W);
  localparam logic [NUM_W-1:0] MS_PER_S = NUM_W'(1000);

  // configuration
  localparam int CFG_IW = 2;
  localparam int CFG_DW = START_W;

  localparam logic signed [START_W-1:0] START_ANGLE_RST = START_W'(-154415);
  localparam logic [STEP_W-1:0] ANGLE_STEP_RST = STEP_W'(286);
  localparam logic [TTC_W-1:0]  TTC_LIMIT_RST  = TTC_W'(1000);

  typedef enum logic [CFG_IW-1:0] {
    CFG_START_ANGLE = 2'd0,
    CFG_ANGLE_STEP  = 2'd1,
    CFG_TTC_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_COS,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_EMIT
  } top_st_t;

  typedef enum logic [2:0] {
    AS_IDLE,
    AS_MUL,
    AS_MOD,
    AS_FOLD,
    AS_IDX,
    AS_DONE
  } ang_st_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_CHECK,
    DV_RUN,
    DV_DONE
  } div_st_t;

  typedef struct packed {
    logic              neg;
    logic [COS_AW-1:0] idx;
  } ang_res_t;

  typedef logic [COS_W-1:0] cos_tab_t [COS_ENTRIES+1];

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // quarter-wave cosine in unsigned q0.15 from a truncated taylor series in q30
  function automatic cos_tab_t cos_table();
    cos_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] p;
    logic [63:0] q;
    int          k;
    int          i;
    for (k = 0; k <= COS_ENTRIES; k++) begin
      x  = (64'(k) * HALF_PI_Q30) / 64'(COS_ENTRIES);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (i = 0; i < 6; i++) begin
        p = (x2 * t) >> 30;
        case (i)
          0:       p = p / 64'd132;
          1:       p = p / 64'd90;
          2:       p = p / 64'd56;
          3:       p = p / 64'd30;
          4:       p = p / 64'd12;
          default: p = p / 64'd2;
        endcase
        t = (p >= Q30_ONE) ? 64'd0 : (Q30_ONE - p);
      end
      q = (t + 64'd16384) >> 15;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = COS_W'(q);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ttceb_ifs.sv @@
// channel interfaces: sample input, result output, configuration write
`default_nettype none

interface ttceb_sample_if;
  import ttceb_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [SPEED_W-1:0] speed_mm_s;
  logic [RANGE_W-1:0]        range_mm;
  logic                      last_beam;

  modport source(output valid, func, speed_mm_s, range_mm, last_beam, input ready);
  modport sink(input valid, func, speed_mm_s, range_mm, last_beam, output ready);
endinterface

interface ttceb_result_if;
  import ttceb_pkg::*;
  logic             valid;
  logic             ready;
  logic             brake;
  logic [TTC_W-1:0] min_ttc_ms;
  logic             found;

  modport source(output valid, brake, min_ttc_ms, found, input ready);
  modport sink(input valid, brake, min_ttc_ms, found, output ready);
endinterface

interface ttceb_cfg_if;
  import ttceb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ttc_emergency_brake.sv @@
// time-to-collision emergency brake: scan sequencer, scan state and result register
//
// sample channel: a beat with func 0 stores a new vehicle speed (mm/s); ready stays high,
// so the next beat can follow in the next cycle. a beat with func 1 is one lidar range
// sample; its angle is the start angle plus beam index times step, and its closing speed
// is speed times cos. after a range beat ready stays low until the beat is through: the
// angle reduction and rom index division, one bit per cycle, the closing speed product,
// the check, the bit-serial ttc division (cut short when the quotient saturates, left out
// for a skipped beam: zero range or no closing speed) and the minimum update.
// a range beat with last_beam set then loads the result register with the scan minimum,
// the found flag and the brake flag in an emit step, then clears the scan.
// the result register holds while the receiver stalls; the next sample is still taken,
// and a later scan end waits only while the previous result is still held.
// cfg channel: ready whenever out of reset; writes start angle, angle step and ttc limit,
// meant for idle periods. unknown indexes are ignored.
// reset (synchronous): speed 0, beam index 0, minimum 65535, found 0, registers to their
// defaults, result channel empty, no beat taken while reset is high.
`default_nettype none

module ttc_emergency_brake (
  input  logic            clk,
  input  logic            rst,
  ttceb_sample_if.sink    sample,
  ttceb_result_if.source  result,
  ttceb_cfg_if.sink       cfg
);
  import ttceb_pkg::*;

  top_st_t                    state, state_next;

  logic signed [START_W-1:0]  start_angle;
  logic [STEP_W-1:0]          angle_step;
  logic [TTC_W-1:0]           ttc_limit;

  logic signed [SPEED_W-1:0]  speed;
  logic [BEAM_W-1:0]          beam_index;
  logic [TTC_W-1:0]           run_min;
  logic                       any_found;

  logic [RANGE_W-1:0]         cur_range;
  logic                       cur_last;
  logic signed [31:0]         closing;
  logic                       elig;

  logic                       out_valid;
  logic                       out_brake;
  logic [TTC_W-1:0]           out_min;
  logic                       out_found;

  logic                       ready;
  logic                       accept;
  logic                       ang_start;
  logic                       ang_done;
  ang_res_t                   ang_res;
  logic [COS_W-1:0]           rom_data;
  logic signed [15:0]         cos_val;
  logic                       eligible;
  logic                       div_start;
  logic                       div_done;
  logic [QUO_W-1:0]           div_quo;
  logic [NUM_W-1:0]           div_num;
  logic                       load_out;

  ttceb_angle u_angle (
    .clk         (clk),
    .rst         (rst),
    .start       (ang_start),
    .start_angle (start_angle),
    .angle_step  (angle_step),
    .beam_index  (beam_index),
    .done        (ang_done),
    .res         (ang_res)
  );

  ttceb_cos_rom u_cos_rom (
    .clk  (clk),
    .addr (ang_res.idx),
    .data (rom_data)
  );

  ttceb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (closing[DEN_W-1:0]),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign accept   = sample.valid && ready;
  assign cos_val  = ang_res.neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
  assign eligible = (cur_range != '0) && !closing[31] && (closing != '0);
  assign div_num  = (NUM_W'(cur_range) * MS_PER_S) << 15;

  assign sample.ready      = ready;
  assign cfg.ready         = !rst;
  assign result.valid      = out_valid;
  assign result.brake      = out_brake;
  assign result.min_ttc_ms = out_min;
  assign result.found      = out_found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ready      = 1'b0;
    ang_start  = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ready = !rst;
        if (sample.valid && sample.func) begin
          ang_start  = 1'b1;
          state_next = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        if (ang_done) begin
          state_next = ST_COS;
        end
      end
      ST_COS: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (eligible) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = cur_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid || result.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // config registers and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_ANGLE_RST;
      angle_step  <= ANGLE_STEP_RST;
      ttc_limit   <= TTC_LIMIT_RST;
      speed       <= '0;
      beam_index  <= '0;
      run_min     <= '1;
      any_found   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.index))
          CFG_START_ANGLE: start_angle <= cfg.data[START_W-1:0];
          CFG_ANGLE_STEP:  angle_step  <= cfg.data[STEP_W-1:0];
          CFG_TTC_LIMIT:   ttc_limit   <= cfg.data[TTC_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (!sample.func) begin
          speed <= sample.speed_mm_s;
        end else if (beam_index != BEAM_W'(MAX_BEAMS - 1)) begin
          beam_index <= beam_index + BEAM_W'(1);
        end
      end
      if (state == ST_UPDATE && elig) begin
        any_found <= 1'b1;
        if (div_quo < run_min) begin
          run_min <= div_quo;
        end
      end
      if (load_out) begin
        out_valid  <= 1'b1;
        beam_index <= '0;
        run_min    <= '1;
        any_found  <= 1'b0;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // beat payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_range <= sample.range_mm;
      cur_last  <= sample.last_beam;
    end
    if (state == ST_COS) begin
      closing <= speed * cos_val;
    end
    if (state == ST_CHECK) begin
      elig <= eligible;
    end
    if (load_out) begin
      out_brake <= (run_min < ttc_limit);
      out_min   <= run_min;
      out_found <= any_found;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ttceb_cos_rom.sv @@
// quarter-wave cosine rom with registered read
`default_nettype none

module ttceb_cos_rom (
  input  logic                          clk,
  input  logic [ttceb_pkg::COS_AW-1:0]  addr,
  output logic [ttceb_pkg::COS_W-1:0]   data
);
  import ttceb_pkg::*;

  localparam cos_tab_t ROM = cos_table();

  always_ff @(posedge clk) begin
    data <= ROM[addr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/ttceb_angle.sv @@
// beam angle, serial reduction modulo two pi and serial rom index division
`default_nettype none

module ttceb_angle (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [ttceb_pkg::START_W-1:0] start_angle,
  input  logic [ttceb_pkg::STEP_W-1:0]        angle_step,
  input  logic [ttceb_pkg::BEAM_W-1:0]        beam_index,
  output logic                                done,
  output ttceb_pkg::ang_res_t                 res
);
  import ttceb_pkg::*;

  ang_st_t                    state, state_next;
  logic [BEAM_W+STEP_W-1:0]   prod, prod_next;
  logic [SH_W-1:0]            rem, rem_next;
  logic [SH_W-1:0]            dsh, dsh_next;
  logic [COS_AW-1:0]          quo, quo_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic                       neg, neg_next;

  logic signed [ANG_W:0]      angle;
  logic [ANG_W-1:0]           mag;
  logic                       ge;
  logic [SH_W-1:0]            diff;
  logic [SH_W-1:0]            a1;
  logic [SH_W-1:0]            a2;
  logic                       past_half;

  always_comb begin
    angle     = (ANG_W+1)'(start_angle) + (ANG_W+1)'($signed({1'b0, prod}));
    mag       = angle[ANG_W] ? ANG_W'(-angle) : angle[ANG_W-1:0];
    ge        = (rem >= dsh);
    diff      = rem - dsh;
    a1        = (rem > PI_Q16) ? (TWO_PI_Q16 - rem) : rem;
    past_half = (a1 > HALF_PI_Q16);
    a2        = past_half ? (PI_Q16 - a1) : a1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_next;
    rem  <= rem_next;
    dsh  <= dsh_next;
    quo  <= quo_next;
    cnt  <= cnt_next;
    neg  <= neg_next;
  end

  always_comb begin
    state_next = state;
    prod_next  = prod;
    rem_next   = rem;
    dsh_next   = dsh;
    quo_next   = quo;
    cnt_next   = cnt;
    neg_next   = neg;
    done       = 1'b0;
    unique case (state)
      AS_IDLE: begin
        if (start) begin
          prod_next  = (BEAM_W+STEP_W)'(beam_index) * (BEAM_W+STEP_W)'(angle_step);
          state_next = AS_MUL;
        end
      end
      AS_MUL: begin
        rem_next   = SH_W'(mag);
        dsh_next   = TWO_PI_Q16 << (MOD_STEPS - 1);
        cnt_next   = CNT_W'(MOD_STEPS - 1);
        state_next = AS_MOD;
      end
      AS_MOD: begin
        if (ge) begin
          rem_next = diff;
        end
        dsh_next = dsh >> 1;
        if (cnt == '0) begin
          state_next = AS_FOLD;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      AS_FOLD: begin
        rem_next   = a2 * COS_SCALE + HALF_ROUND;
        neg_next   = past_half;
        dsh_next   = HALF_PI_Q16 << (COS_AW - 1);
        cnt_next   = CNT_W'(COS_AW - 1);
        quo_next   = '0;
        state_next = AS_IDX;
      end
      AS_IDX: begin
        if (ge) begin
          rem_next = diff;
        end
        quo_next = {quo[COS_AW-2:0], ge};
        dsh_next = dsh >> 1;
        if (cnt == '0) begin
          state_next = AS_DONE;
        end else begin
          cnt_next = cnt - CNT_W'(1);
        end
      end
      AS_DONE: begin
        done       = 1'b1;
        state_next = AS_IDLE;
      end
      default: begin
        state_next = AS_IDLE;
      end
    endcase
  end

  assign res.neg = neg;
  assign res.idx = (quo > COS_LAST) ? COS_LAST : quo;

endmodule

`default_nettype wire

@@ hw/rtl/ttceb_div.sv @@
// bit-serial ttc divider with saturation to the quotient width
`default_nettype none

module ttceb_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ttceb_pkg::NUM_W-1:0]   num,
  input  logic [ttceb_pkg::DEN_W-1:0]   den,
  output logic                          done,
  output logic [ttceb_pkg::QUO_W-1:0]   quo
);
  import ttceb_pkg::*;

  div_st_t            state, state_next;
  logic [NUM_W-1:0]   rem, rem_next;
  logic [DSH_W-1:0]   dsh, dsh_next;
  logic [QUO_W-1:0]   quo_next;
  logic [DCNT_W-1:0]  cnt, cnt_next;
  logic               ge;

  assign ge = (DSH_W'(rem) >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
    dsh <= dsh_next;
    quo <= quo_next;
    cnt <= cnt_next;
  end

  always_comb begin
    state_next = state;
    rem_next   = rem;
    dsh_next   = dsh;
    quo_next   = quo;
    cnt_next   = cnt;
    done       = 1'b0;
    unique case (state)
      DV_IDLE: begin
        if (start) begin
          rem_next   = num;
          dsh_next   = {den, {QUO_W{1'b0}}};
          state_next = DV_CHECK;
        end
      end
      DV_CHECK: begin
        // quotient would not fit: saturate
        if (ge) begin
          quo_next   = '1;
          state_next = DV_DONE;
        end else begin
          quo_next   = '0;
          dsh_next   = dsh >> 1;
          cnt_next   = DCNT_W'(QUO_W - 1);
          state_next = DV_RUN;
        end
      end
      DV_RUN: begin
        if (ge) begin
          rem_next = rem - dsh[NUM_W-1:0];
        end
        quo_next = {quo[QUO_W-2:0], ge};
        dsh_next = dsh >> 1;
        if (cnt == '0) begin
          state_next = DV_DONE;
        end else begin
          cnt_next = cnt - DCNT_W'(1);
        end
      end
      DV_DONE: begin
        done       = 1'b1;
        state_next = DV_IDLE;
      end
      default: begin
        state_next = DV_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
